// File: hw/rtl/rkg_pkg.sv
package rkg_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int EV_WIDTH    = 3;
    localparam int MODE_WIDTH  = 3;
    localparam int GEST_WIDTH  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = CFG_WIDTH'(500);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [EV_WIDTH-1:0]    event_t;
    typedef logic [MODE_WIDTH-1:0]  mode_t;
    typedef logic [GEST_WIDTH-1:0]  gesture_t;

    localparam event_t EV_DOWN  = 3'd0;
    localparam event_t EV_UP    = 3'd1;
    localparam event_t EV_LEFT  = 3'd2;
    localparam event_t EV_RIGHT = 3'd3;
    localparam event_t EV_TOUT  = 3'd4;
    localparam event_t EV_NONE  = 3'd5;

    localparam mode_t M_IDLE  = 3'd0;
    localparam mode_t M_PRESS = 3'd1;
    localparam mode_t M_LONG1 = 3'd2;
    localparam mode_t M_LONG2 = 3'd3;
    localparam mode_t M_KEY   = 3'd4;

    localparam gesture_t G_NONE      = 3'd0;
    localparam gesture_t G_LEFT      = 3'd1;
    localparam gesture_t G_RIGHT     = 3'd2;
    localparam gesture_t G_CLICK     = 3'd3;
    localparam gesture_t G_LONG1     = 3'd4;
    localparam gesture_t G_LONG2     = 3'd5;
    localparam gesture_t G_PRESS_LFT = 3'd6;
    localparam gesture_t G_PRESS_RGT = 3'd7;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hw/rtl/rkg_front.sv
module rkg_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              switch_level,
    input  logic                              left_level,
    input  logic                              right_level,
    input  logic [rkg_pkg::CFG_WIDTH-1:0]     timeout_ticks,
    output rkg_pkg::event_t                   ev
);

    logic [2:0]       last_levels_reg;
    logic [2:0]       last_levels_next;
    rkg_pkg::count_t  idle_count_reg;
    rkg_pkg::count_t  idle_count_next;
    rkg_pkg::event_t  edge_ev;

    always_comb
    begin
        edge_ev = rkg_pkg::EV_NONE;
        if (last_levels_reg[0] != switch_level)
        begin
            edge_ev = switch_level ? rkg_pkg::EV_DOWN : rkg_pkg::EV_UP;
        end
        if (last_levels_reg[1] && !left_level)
        begin
            edge_ev = rkg_pkg::EV_LEFT;
        end
        if (last_levels_reg[2] && !right_level)
        begin
            edge_ev = rkg_pkg::EV_RIGHT;
        end
    end

    always_comb
    begin
        ev               = edge_ev;
        last_levels_next = {right_level, left_level, switch_level};
        if (edge_ev != rkg_pkg::EV_NONE)
        begin
            idle_count_next = '0;
        end
        else if (idle_count_reg == rkg_pkg::count_t'(timeout_ticks))
        begin
            idle_count_next = '0;
            ev              = rkg_pkg::EV_TOUT;
        end
        else
        begin
            idle_count_next = idle_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= '0;
            idle_count_reg  <= '0;
        end
        else if (accept)
        begin
            last_levels_reg <= last_levels_next;
            idle_count_reg  <= idle_count_next;
        end
    end

endmodule

// File: hw/rtl/rkg_queue.sv
module rkg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rkg_pkg::event_t      push_ev,
    input  logic                 pop,
    output rkg_pkg::event_t      pop_ev,
    output rkg_pkg::q_status_t   status
);

    rkg_pkg::event_t                 slot_reg [rkg_pkg::QUEUE_DEPTH];
    logic [rkg_pkg::QPTR_WIDTH-1:0]  wr_ptr_reg;
    logic [rkg_pkg::QPTR_WIDTH-1:0]  rd_ptr_reg;
    logic [rkg_pkg::QCNT_WIDTH-1:0]  count_reg;
    logic [rkg_pkg::QCNT_WIDTH-1:0]  count_next;

    assign pop_ev       = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == rkg_pkg::QCNT_WIDTH'(rkg_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/rkg_back.sv
module rkg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop,
    input  rkg_pkg::event_t      ev,
    input  logic                 out_ready,
    output logic                 out_valid,
    output rkg_pkg::gesture_t    gesture
);

    rkg_pkg::mode_t     mode_reg;
    rkg_pkg::mode_t     mode_next;
    rkg_pkg::gesture_t  gesture_reg;
    rkg_pkg::gesture_t  gesture_next;
    logic               valid_reg;

    assign out_valid = valid_reg;
    assign gesture   = gesture_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        gesture_next = rkg_pkg::G_NONE;
        case (mode_reg)
            rkg_pkg::M_PRESS:
            begin
                if (ev == rkg_pkg::EV_UP)
                begin
                    gesture_next = rkg_pkg::G_CLICK;
                    mode_next    = rkg_pkg::M_IDLE;
                end
                else if (ev == rkg_pkg::EV_LEFT)
                begin
                    gesture_next = rkg_pkg::G_PRESS_LFT;
                    mode_next    = rkg_pkg::M_KEY;
                end
                else if (ev == rkg_pkg::EV_RIGHT)
                begin
                    gesture_next = rkg_pkg::G_PRESS_RGT;
                    mode_next    = rkg_pkg::M_KEY;
                end
                else if (ev == rkg_pkg::EV_TOUT)
                begin
                    gesture_next = rkg_pkg::G_LONG1;
                    mode_next    = rkg_pkg::M_LONG1;
                end
            end
            rkg_pkg::M_LONG1:
            begin
                if (ev == rkg_pkg::EV_UP)
                begin
                    mode_next = rkg_pkg::M_IDLE;
                end
                else if (ev == rkg_pkg::EV_TOUT)
                begin
                    gesture_next = rkg_pkg::G_LONG2;
                    mode_next    = rkg_pkg::M_LONG2;
                end
            end
            rkg_pkg::M_LONG2:
            begin
                if (ev == rkg_pkg::EV_UP)
                begin
                    mode_next = rkg_pkg::M_IDLE;
                end
            end
            rkg_pkg::M_KEY:
            begin
                if (ev == rkg_pkg::EV_UP)
                begin
                    mode_next = rkg_pkg::M_IDLE;
                end
                else if (ev == rkg_pkg::EV_LEFT)
                begin
                    gesture_next = rkg_pkg::G_PRESS_LFT;
                end
                else if (ev == rkg_pkg::EV_RIGHT)
                begin
                    gesture_next = rkg_pkg::G_PRESS_RGT;
                end
            end
            default:
            begin
                // idle, and any unused code behaves as idle
                mode_next = rkg_pkg::M_IDLE;
                if (ev == rkg_pkg::EV_DOWN)
                begin
                    mode_next = rkg_pkg::M_PRESS;
                end
                else if (ev == rkg_pkg::EV_LEFT)
                begin
                    gesture_next = rkg_pkg::G_LEFT;
                end
                else if (ev == rkg_pkg::EV_RIGHT)
                begin
                    gesture_next = rkg_pkg::G_RIGHT;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            gesture_reg <= gesture_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rkg_pkg::M_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/rotary_knob_gesture_decoder_top.sv
// rotary knob gesture decoder
// input stream: one word per sample tick of the knob, carrying the push
// switch level and the left and right pulse line levels. every accepted
// word gives exactly one output word holding a gesture code (0 when the
// tick produced nothing).
// the front stage detects edges and runs the idle timer, and writes one
// event per tick into a two-entry event queue. the back stage runs the
// gesture state machine out of that queue into an output register.
// throughput: one word per cycle in both directions while the receiver takes every word, no bubbles.
// the accepting edge writes the event into the queue; the edge that reads it
// from the queue steps the state machine into the output register, where it is valid.
// when the receiver stalls, the output register holds its word and the
// queue absorbs up to two further words; s_tready then drops until the
// receiver takes the held word.
// reset: levels and idle count clear to zero, mode to idle, queue and
// output empty, timeout_ticks back to 500.
// cfg_we writes timeout_ticks; write only while idle.
module rotary_knob_gesture_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // switch_level, left_level, right_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // gesture[2:0]
    input  logic                            cfg_we,
    input  logic [rkg_pkg::CFG_WIDTH-1:0]   cfg_wdata
);

    logic [rkg_pkg::CFG_WIDTH-1:0]  timeout_reg;
    logic                           in_accept;
    logic                           q_pop;
    rkg_pkg::event_t                front_ev;
    rkg_pkg::event_t                q_ev;
    rkg_pkg::q_status_t             q_status;
    rkg_pkg::gesture_t              gesture;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rkg_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    assign s_tready  = !q_status.full;
    assign in_accept = s_tvalid && s_tready;
    assign q_pop     = !q_status.empty && (!m_tvalid || m_tready);
    assign m_tdata   = {5'b0, gesture};

    rkg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .switch_level  (s_tdata[0]),
        .left_level    (s_tdata[1]),
        .right_level   (s_tdata[2]),
        .timeout_ticks (timeout_reg),
        .ev            (front_ev)
    );

    rkg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_accept),
        .push_ev (front_ev),
        .pop     (q_pop),
        .pop_ev  (q_ev),
        .status  (q_status)
    );

    rkg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (q_pop),
        .ev        (q_ev),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .gesture   (gesture)
    );

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_status.empty))
        else $error("event queue popped while empty");

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && q_status.full))
        else $error("event queue written while full");

    a_valid_from_pop : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("output word appeared without a queue read");

    a_queue_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !m_tvalid) |=> m_tvalid)
        else $error("pending event not moved to the output");

endmodule

// File: sim/rotary_knob_gesture_decoder_top_test.sv
`timescale 1ns / 1ps

module rotary_knob_gesture_decoder_top_test;

    localparam int CYCLE_LIMIT = 100000;
    localparam int LONG_STALL  = 60;
    localparam int DRAIN_WAIT  = 4;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = 8'd0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [7:0]                    m_tdata;
    logic                          cfg_we    = 1'b0;
    logic [rkg_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;

    // knob levels are kept as {right, left, switch}
    logic [2:0]                    pending_samples[$];
    rkg_pkg::gesture_t             expected_gestures[$];

    logic [2:0]                    knob_levels;
    rkg_pkg::count_t               idle_ticks;
    rkg_pkg::mode_t                knob_mode;
    logic [rkg_pkg::CFG_WIDTH-1:0] timeout_cfg;

    logic [2:0]           gen_levels  = 3'b000;
    int                   queued_total = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   stall_left  = 0;
    bit                   long_stall_req = 1'b0;
    bit                   in_taken = 1'b0;

    rotary_knob_gesture_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic rkg_pkg::gesture_t decode_gesture(input logic [2:0] lv);
        rkg_pkg::event_t   ev;
        rkg_pkg::gesture_t g;
        rkg_pkg::mode_t    m;
        ev = rkg_pkg::EV_NONE;
        g  = rkg_pkg::G_NONE;
        m  = knob_mode;
        if (knob_levels[0] != lv[0])
            ev = lv[0] ? rkg_pkg::EV_DOWN : rkg_pkg::EV_UP;
        if (knob_levels[1] && !lv[1])
            ev = rkg_pkg::EV_LEFT;
        if (knob_levels[2] && !lv[2])
            ev = rkg_pkg::EV_RIGHT;
        knob_levels = lv;

        if (ev != rkg_pkg::EV_NONE)
            idle_ticks = '0;
        else if (idle_ticks == rkg_pkg::count_t'(timeout_cfg))
        begin
            idle_ticks = '0;
            ev = rkg_pkg::EV_TOUT;
        end
        else
            idle_ticks = idle_ticks + 1'b1;

        case (m)
            rkg_pkg::M_PRESS:
            begin
                if (ev == rkg_pkg::EV_UP)
                begin
                    g = rkg_pkg::G_CLICK;
                    m = rkg_pkg::M_IDLE;
                end
                else if (ev == rkg_pkg::EV_LEFT)
                begin
                    g = rkg_pkg::G_PRESS_LFT;
                    m = rkg_pkg::M_KEY;
                end
                else if (ev == rkg_pkg::EV_RIGHT)
                begin
                    g = rkg_pkg::G_PRESS_RGT;
                    m = rkg_pkg::M_KEY;
                end
                else if (ev == rkg_pkg::EV_TOUT)
                begin
                    g = rkg_pkg::G_LONG1;
                    m = rkg_pkg::M_LONG1;
                end
            end
            rkg_pkg::M_LONG1:
            begin
                if (ev == rkg_pkg::EV_UP)
                    m = rkg_pkg::M_IDLE;
                else if (ev == rkg_pkg::EV_TOUT)
                begin
                    g = rkg_pkg::G_LONG2;
                    m = rkg_pkg::M_LONG2;
                end
            end
            rkg_pkg::M_LONG2:
            begin
                if (ev == rkg_pkg::EV_UP)
                    m = rkg_pkg::M_IDLE;
            end
            rkg_pkg::M_KEY:
            begin
                if (ev == rkg_pkg::EV_UP)
                    m = rkg_pkg::M_IDLE;
                else if (ev == rkg_pkg::EV_LEFT)
                    g = rkg_pkg::G_PRESS_LFT;
                else if (ev == rkg_pkg::EV_RIGHT)
                    g = rkg_pkg::G_PRESS_RGT;
            end
            default:
            begin
                // unused codes behave as idle
                m = rkg_pkg::M_IDLE;
                if (ev == rkg_pkg::EV_DOWN)
                    m = rkg_pkg::M_PRESS;
                else if (ev == rkg_pkg::EV_LEFT)
                    g = rkg_pkg::G_LEFT;
                else if (ev == rkg_pkg::EV_RIGHT)
                    g = rkg_pkg::G_RIGHT;
            end
        endcase
        knob_mode = m;
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_sample(input logic [2:0] lv);
        pending_samples.push_back(lv);
        gen_levels = lv;
        queued_total++;
    endtask

    task automatic turn_step(input int line);
        logic [2:0] lv;
        lv = gen_levels;
        lv[line] = 1'b1;
        push_sample(lv);
        lv[line] = 1'b0;
        push_sample(lv);
    endtask

    task automatic add_random_samples(input int count, input int hold_max);
        int target;
        int pick;
        target = queued_total + count;
        while (queued_total < target)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                // plain turns
                repeat ($urandom_range(1, 3))
                    turn_step($urandom_range(1, 2));
            end
            else if (pick < 35)
            begin
                // short click
                push_sample(gen_levels | 3'b001);
                repeat ($urandom_range(0, 2))
                    push_sample(gen_levels);
                push_sample(gen_levels & 3'b110);
            end
            else if (pick < 55)
            begin
                // held press, may run into long clicks
                push_sample(gen_levels | 3'b001);
                repeat ($urandom_range(0, hold_max))
                    push_sample(gen_levels);
                push_sample(gen_levels & 3'b110);
            end
            else if (pick < 75)
            begin
                // press and turn
                push_sample(gen_levels | 3'b001);
                repeat ($urandom_range(1, 4))
                    turn_step($urandom_range(1, 2));
                repeat ($urandom_range(0, 2))
                    push_sample(gen_levels);
                push_sample(gen_levels & 3'b110);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, hold_max + 1))
                    push_sample(gen_levels);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_sample(3'($urandom_range(7)));
            end
        end
    endtask

    task automatic wait_for_drain;
        while (pending_samples.size() != 0 || expected_gestures.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [rkg_pkg::CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        timeout_cfg = value;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_taken)
            s_tvalid <= 1'b1;
        else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {5'b00000, pending_samples[0]};
        end
        else
            s_tvalid <= 1'b0;
        in_taken = 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            stall_left = LONG_STALL;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // word accept on both sides
    always @(posedge clk)
    begin : monitor
        rkg_pkg::gesture_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_gestures.push_back(decode_gesture(pending_samples[0]));
                void'(pending_samples.pop_front());
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_gestures.size() == 0)
                    report_mismatch("unexpected word, gesture", m_tdata[2:0], -1);
                else
                begin
                    want = expected_gestures.pop_front();
                    if (m_tdata[2:0] != want)
                        report_mismatch("gesture", m_tdata[2:0], want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        knob_levels   = 3'b000;
        idle_ticks    = '0;
        knob_mode     = rkg_pkg::M_IDLE;
        timeout_cfg   = rkg_pkg::TIMEOUT_RESET;
        send_idle_pct = 25;
        recv_idle_pct = 85;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // turns, click and press-turn at the reset timeout
        push_sample(3'b010);
        push_sample(3'b000);
        push_sample(3'b100);
        push_sample(3'b000);
        push_sample(3'b001);
        push_sample(3'b000);
        push_sample(3'b111);
        push_sample(3'b101);
        push_sample(3'b001);
        push_sample(3'b111);
        // release with both lines falling: right wins
        push_sample(3'b000);
        push_sample(3'b000);
        push_sample(3'b001);
        push_sample(3'b000);
        wait_for_drain();

        // long click 1, long click 2, hold in long-2, release
        write_timeout(rkg_pkg::CFG_WIDTH'(2));
        push_sample(3'b001);
        repeat (9)
            push_sample(3'b001);
        push_sample(3'b000);
        wait_for_drain();

        write_timeout('0);
        add_random_samples(130, 4);
        wait_for_drain();

        send_idle_pct = 85;
        recv_idle_pct = 25;
        write_timeout(rkg_pkg::CFG_WIDTH'(5));
        add_random_samples(130, 14);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout('1);
        add_random_samples(70, 6);
        @(posedge clk);
        long_stall_req = 1'b1;
        wait_for_drain();

        write_timeout(rkg_pkg::CFG_WIDTH'(1));
        add_random_samples(70, 6);
        wait_for_drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: rotary_knob_gesture_decoder_top.f
hw/rtl/rkg_pkg.sv
hw/rtl/rkg_front.sv
hw/rtl/rkg_queue.sv
hw/rtl/rkg_back.sv
hw/rtl/rotary_knob_gesture_decoder_top.sv
sim/rotary_knob_gesture_decoder_top_test.sv
